### hw/rtl/lesf_pkg.sv
// Shared types and constants of the largest empty square finder.
package lesf_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned SideW   = 11;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;

  localparam logic [CharW-1:0] FreeChar = 8'd46;
  localparam logic [SideW-1:0] SideMax  = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1
  } lesf_reg_e;

  // Control of one computed cell handed to the best-square tracker.
  typedef struct packed {
    logic valid;
    logic last;
  } lesf_ctl_t;

  function automatic logic [SideW-1:0] min3(input logic [SideW-1:0] a,
                                            input logic [SideW-1:0] b,
                                            input logic [SideW-1:0] c);
    logic [SideW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

### hw/rtl/lesf_line_store.sv
// One-row line store: single write port, registered read with write forwarding.
module lesf_line_store import lesf_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
  input  logic                                     clk_i,
  input  logic                                     rd_en_i,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] rd_addr_i,
  output logic [SideW-1:0]                         rd_data_o,
  input  logic                                     wr_en_i,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] wr_addr_i,
  input  logic [SideW-1:0]                         wr_data_i
);

  logic [SideW-1:0] mem_q [MAX_WIDTH];
  logic [SideW-1:0] rdata_q;
  logic [SideW-1:0] fwd_data_q;
  logic             fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // A read that hits the entry written in the same cycle takes the new value.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q    <= mem_q[rd_addr_i];
      fwd_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

### hw/rtl/lesf_best_track.sv
// Best-square tracker and result output register.
module lesf_best_track import lesf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  lesf_ctl_t                                          cell_ctl_i,
  input  logic [SideW-1:0]                                   side_i,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0]   col_i,
  input  logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] row_i,
  input  logic                                               out_ready_i,
  output logic                                               out_valid_o,
  output logic                                               out_full_o,
  output logic [SideW-1:0]                                   best_size_o,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0]   best_column_o,
  output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] best_row_o
);

  localparam int unsigned ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [SideW-1:0] best_side_q, best_side_d;
  logic [ColW-1:0]  best_col_q, best_col_d;
  logic [RowW-1:0]  best_row_q, best_row_d;
  logic             out_valid_q, out_valid_d;
  logic [SideW-1:0] out_size_q;
  logic [ColW-1:0]  out_col_q;
  logic [RowW-1:0]  out_row_q;
  logic             better;

  // Strictly larger only: ties keep the earlier square.
  always_comb begin
    better      = side_i > best_side_q;
    best_side_d = better ? side_i : best_side_q;
    best_col_d  = better ? col_i  : best_col_q;
    best_row_d  = better ? row_i  : best_row_q;
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cell_ctl_i.valid && cell_ctl_i.last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_side_q <= '0;
      best_col_q  <= '0;
      best_row_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cell_ctl_i.valid) begin
        if (cell_ctl_i.last) begin
          best_side_q <= '0;
          best_col_q  <= '0;
          best_row_q  <= '0;
        end else begin
          best_side_q <= best_side_d;
          best_col_q  <= best_col_d;
          best_row_q  <= best_row_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_ctl_i.valid && cell_ctl_i.last) begin
      out_size_q <= best_side_d;
      out_col_q  <= best_col_d;
      out_row_q  <= best_row_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_full_o    = out_valid_q && !out_ready_i;
  assign best_size_o   = out_size_q;
  assign best_column_o = out_col_q;
  assign best_row_o    = out_row_q;

endmodule

### hw/rtl/largest_empty_square_finder_core.sv
// Top level of the largest empty square finder: counters, cell stage, line store, best-square tracker.
//
//  channel   direction  handshake                  payload
//  in        input      in_valid_i / in_ready_o    cell_char_i
//  out       output     out_valid_o / out_ready_i  best_size_o, best_column_o, best_row_o
//  cfg       input      cfg_we_i (no wait)         cfg_index_i, cfg_wdata_i
//
// One cell per cycle while the cell stage is not held; each cell does one line-store
// read at acceptance and one write when it leaves the cell stage, which sets the rate.
// A result is valid once the last cell of a grid has left the cell stage and loaded the output register.
// Reset clears counters and the best square; the line store needs no clearing.
// A result not yet taken stalls input only when the next grid's last cell
// reaches the cell stage.
module largest_empty_square_finder_core import lesf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               in_valid_i,
  output logic                                               in_ready_o,
  input  logic [CharW-1:0]                                   cell_char_i,
  output logic                                               out_valid_o,
  input  logic                                               out_ready_i,
  output logic [SideW-1:0]                                   best_size_o,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0]   best_column_o,
  output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] best_row_o,
  input  logic                                               cfg_we_i,
  input  logic [CfgIdxW-1:0]                                 cfg_index_i,
  input  logic [CfgW-1:0]                                    cfg_wdata_i
);

  localparam int unsigned ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [CfgW-1:0]  grid_width_q, grid_height_q;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             col_last, row_last, accept;

  logic             s1_valid_q, s1_valid_d;
  logic             s1_free_q, s1_last_q;
  logic [ColW-1:0]  s1_col_q;
  logic [RowW-1:0]  s1_row_q;
  logic             s1_adv, out_full;

  logic [SideW-1:0] left_q, diag_q;
  logic [SideW-1:0] rd_data, above, left_v, diag_v, side;
  logic [SideW:0]   side_sum;
  lesf_ctl_t        cell_ctl;

  // Configuration: zero reads as one, large values saturate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= CfgW'(1);
      grid_height_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      case (lesf_reg_e'(cfg_index_i))
        REG_GRID_WIDTH: begin
          if (cfg_wdata_i == '0) begin
            grid_width_q <= CfgW'(1);
          end else if (32'(cfg_wdata_i) > MAX_WIDTH) begin
            grid_width_q <= CfgW'(MAX_WIDTH);
          end else begin
            grid_width_q <= cfg_wdata_i;
          end
        end
        REG_GRID_HEIGHT: begin
          if (cfg_wdata_i == '0) begin
            grid_height_q <= CfgW'(1);
          end else if (32'(cfg_wdata_i) > MAX_HEIGHT) begin
            grid_height_q <= CfgW'(MAX_HEIGHT);
          end else begin
            grid_height_q <= cfg_wdata_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the cell stage when its last cell cannot load the output register.
  assign s1_adv     = s1_valid_q && !(s1_last_q && out_full);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    col_last = (32'(col_q) + 32'd1) >= 32'(grid_width_q);
    row_last = (32'(row_q) + 32'd1) >= 32'(grid_height_q);
    col_d    = col_q;
    row_d    = row_q;
    if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q && !s1_adv;
    if (accept) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      left_q     <= '0;
      diag_q     <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        left_q <= side;
        diag_q <= above;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_free_q <= cell_char_i == FreeChar;
      s1_last_q <= col_last && row_last;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
    end
  end

  lesf_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i (side)
  );

  // Neighbors outside the grid count as zero.
  always_comb begin
    above    = (s1_row_q != '0) ? rd_data : '0;
    left_v   = (s1_col_q != '0) ? left_q : '0;
    diag_v   = ((s1_col_q != '0) && (s1_row_q != '0)) ? diag_q : '0;
    side_sum = {1'b0, min3(above, left_v, diag_v)} + (SideW+1)'(1);
    if (!s1_free_q) begin
      side = '0;
    end else if (side_sum[SideW]) begin
      side = SideMax;
    end else begin
      side = side_sum[SideW-1:0];
    end
  end

  assign cell_ctl.valid = s1_adv;
  assign cell_ctl.last  = s1_last_q;

  lesf_best_track #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_best_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cell_ctl_i    (cell_ctl),
    .side_i        (side),
    .col_i         (s1_col_q),
    .row_i         (s1_row_q),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .out_full_o    (out_full),
    .best_size_o   (best_size_o),
    .best_column_o (best_column_o),
    .best_row_o    (best_row_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> !in_ready_o)
    else $error("input taken while the cell stage is held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid_q && s1_last_q))
    else $error("result without a last cell of a grid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q && out_full) |=> (s1_valid_q && s1_last_q))
    else $error("last cell dropped while the output register was full");

endmodule
